>>> rtl/krsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krsr_pkg: shared definitions for the keyed registry
// Field widths, request codes, controller states and the default table depth.
// ----------------------------------------------------------------------------
package krsr_pkg;

    // Default number of table entries.
    localparam int MAX_ENTRIES_DEF = 32;

    // Fixed field widths of the transaction payloads.
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 11;
    localparam int HANDLE_W = 32;
    localparam int OCC_W    = 11;

    // Key value returned when a reverse lookup finds nothing.
    localparam logic [KEY_W-1:0] KEY_NONE = '1;

    // Request codes; the remaining codes are treated as no-operation requests.
    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTER    = 3'd0,
        KIND_UNREGISTER  = 3'd1,
        KIND_BODY_BY_KEY = 3'd2,
        KIND_KEY_BY_BODY = 3'd3,
        KIND_CLEAR       = 3'd4
    } t_kind;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_RESP
    } t_state;

endpackage

>>> rtl/krsr_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krsr_match: entry compare for the table scan
// Decides whether one entry read from the table satisfies the current request.
// ----------------------------------------------------------------------------
module krsr_match #(
    parameter int IW = 5
) (
    input  krsr_pkg::t_kind                  i_kind,
    input  logic [IW-1:0]                    i_key,
    input  logic [krsr_pkg::HANDLE_W-1:0]    i_handle,
    input  logic                             i_ent_live,
    input  logic [IW-1:0]                    i_ent_key,
    input  logic [krsr_pkg::HANDLE_W-1:0]    i_ent_handle,
    output logic                             o_match
);
    import krsr_pkg::*;

    logic key_eq;
    logic handle_eq;

    assign key_eq    = (i_ent_key == i_key);
    assign handle_eq = (i_ent_handle == i_handle);

    // Register and unregister match on the key alone; lookups need a live entry.
    always_comb begin
        case (i_kind)
            KIND_REGISTER,
            KIND_UNREGISTER:  o_match = key_eq;
            KIND_BODY_BY_KEY: o_match = i_ent_live & key_eq;
            KIND_KEY_BY_BODY: o_match = i_ent_live & handle_eq;
            default:          o_match = 1'b0;
        endcase
    end

endmodule

>>> rtl/keyed_registry_swap_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_registry_swap_remove: packed key/handle table with swap removal
// Top level: request controller, entry memory and the result register.
// ----------------------------------------------------------------------------
// Usage:
// One request transaction (kind, slot key, body handle) enters on the input
// channel and produces exactly one result transaction (handle, key, hit,
// occupancy) on the output channel. Both channels use valid/stall; a
// transaction moves on a clock edge with valid high and stall low.
// The table sits in one synchronous memory read once per cycle. A request
// that searches the table streams through the occupied part of it, one entry
// per cycle, and stops at the first match. A clear, a rejected key or an
// unused code goes straight to its result without reading the table.
// A search that finds nothing (lookup miss, register append) reads every
// occupied entry before its result; an unregister that hits an entry other
// than the last one adds a move step that copies the last entry into the
// hole left by the removed one.
// The input stalls while a request is in progress. The finished result waits
// in the output register; the next request is taken meanwhile, and is held
// before its result is loaded while the receiver keeps stalling.
// Reset empties the table at once (occupancy 0); no clearing pass is needed
// since only entries below the occupancy count are ever read.
// ----------------------------------------------------------------------------
module keyed_registry_swap_remove #(
    parameter int MAX_ENTRIES = krsr_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [krsr_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [krsr_pkg::KEY_W-1:0]    i_slot_key,
    input  logic [krsr_pkg::HANDLE_W-1:0]        i_body_handle,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [krsr_pkg::HANDLE_W-1:0]        o_handle_out,
    output logic signed [krsr_pkg::KEY_W-1:0]    o_key_out,
    output logic                                 o_hit,
    output logic [krsr_pkg::OCC_W-1:0]           o_occupancy
);
    import krsr_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = 1 + IW + HANDLE_W;

    // Entry memory: {live, key, handle}.
    logic [WW-1:0] mem [MAX_ENTRIES];

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [WW-1:0] r_rd_data;
    logic          we;
    logic [IW-1:0] waddr;
    logic [WW-1:0] wdata;

    logic                ent_live;
    logic [IW-1:0]       ent_key;
    logic [HANDLE_W-1:0] ent_handle;

    // Controller state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_chk_vld, n_chk_vld;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic [IW-1:0] r_hit_idx, n_hit_idx;

    // Captured request.
    t_kind               r_kind;
    logic [IW-1:0]       r_key;
    logic [HANDLE_W-1:0] r_handle;

    // Result under construction.
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic                r_res_hit, n_res_hit;

    // Output register.
    logic                r_out_vld, n_out_vld;
    logic                out_load;
    logic [HANDLE_W-1:0] r_o_handle;
    logic [KEY_W-1:0]    r_o_key;
    logic                r_o_hit;
    logic [OCC_W-1:0]    r_o_occ;

    logic    in_accept;
    logic    key_ok;
    logic    match;
    t_kind   in_kind;

    // Index of the last occupied entry.
    function automatic logic [IW-1:0] last_entry_idx(input logic [CW-1:0] total);
        logic [CW-1:0] last;
        last = CW'(total - 1'b1);
        return last[IW-1:0];
    endfunction

    assign in_kind   = t_kind'(i_kind);
    assign in_accept = i_in_valid & (r_state == S_IDLE);
    assign key_ok    = ~i_slot_key[KEY_W-1]
                     & ($unsigned(i_slot_key) < KEY_W'(MAX_ENTRIES));

    assign {ent_live, ent_key, ent_handle} = r_rd_data;

    // Entry compare on the word returned by the memory.
    krsr_match #(
        .IW (IW)
    ) u_match (
        .i_kind       (r_kind),
        .i_key        (r_key),
        .i_handle     (r_handle),
        .i_ent_live   (ent_live),
        .i_ent_key    (ent_key),
        .i_ent_handle (ent_handle),
        .o_match      (match)
    );

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Next state, memory control and result building.
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_idx        = r_idx;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_hit_idx    = r_hit_idx;
        n_res_handle = r_res_handle;
        n_res_key    = r_res_key;
        n_res_hit    = r_res_hit;
        n_out_vld    = r_out_vld & i_out_stall;
        out_load     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_idx[IW-1:0];
        we           = 1'b0;
        waddr        = r_chk_idx;
        wdata        = {1'b1, r_key, r_handle};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_handle = '0;
                    n_res_key    = KEY_NONE;
                    n_res_hit    = 1'b0;
                    n_idx        = '0;
                    case (in_kind)
                        KIND_REGISTER,
                        KIND_UNREGISTER,
                        KIND_BODY_BY_KEY: n_state = key_ok ? S_SCAN : S_RESP;
                        KIND_KEY_BY_BODY: n_state = S_SCAN;
                        KIND_CLEAR: begin
                            n_total   = '0;
                            n_res_hit = 1'b1;
                            n_state   = S_RESP;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            S_SCAN: begin
                if (r_chk_vld && match) begin
                    // First matching entry found at r_chk_idx.
                    n_res_hit = 1'b1;
                    n_state   = S_RESP;
                    case (r_kind)
                        KIND_REGISTER: begin
                            we           = 1'b1;
                            n_res_handle = r_handle;
                        end
                        KIND_UNREGISTER: begin
                            if (CW'(r_chk_idx) < CW'(r_total - 1'b1)) begin
                                // Fetch the last entry to move into the hole.
                                rd_en     = 1'b1;
                                rd_addr   = last_entry_idx(r_total);
                                n_hit_idx = r_chk_idx;
                                n_state   = S_MOVE;
                            end else begin
                                n_total = CW'(r_total - 1'b1);
                            end
                        end
                        KIND_BODY_BY_KEY: n_res_handle = ent_handle;
                        KIND_KEY_BY_BODY: n_res_key    = KEY_W'(ent_key);
                        default: n_res_hit = 1'b0;
                    endcase
                end else if (r_idx < r_total) begin
                    // Stream the next entry out of the memory.
                    rd_en     = 1'b1;
                    n_idx     = CW'(r_idx + 1'b1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_idx[IW-1:0];
                end else if (!r_chk_vld) begin
                    // Scan exhausted without a match.
                    n_state = S_RESP;
                    if (r_kind == KIND_REGISTER && r_total < CW'(MAX_ENTRIES)) begin
                        we           = 1'b1;
                        waddr        = r_total[IW-1:0];
                        n_total      = CW'(r_total + 1'b1);
                        n_res_handle = r_handle;
                        n_res_hit    = 1'b1;
                    end
                end
            end

            S_MOVE: begin
                // Write the former last entry over the removed one.
                we      = 1'b1;
                waddr   = r_hit_idx;
                wdata   = r_rd_data;
                n_total = CW'(r_total - 1'b1);
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_hit_idx    <= n_hit_idx;
        r_res_handle <= n_res_handle;
        r_res_key    <= n_res_key;
        r_res_hit    <= n_res_hit;
        if (in_accept) begin
            r_kind   <= in_kind;
            r_key    <= i_slot_key[IW-1:0];
            r_handle <= i_body_handle;
        end
        if (out_load) begin
            r_o_handle <= r_res_handle;
            r_o_key    <= r_res_key;
            r_o_hit    <= r_res_hit;
            r_o_occ    <= OCC_W'(r_total);
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_handle_out = r_o_handle;
    assign o_key_out    = r_o_key;
    assign o_hit        = r_o_hit;
    assign o_occupancy  = r_o_occ;

    // The entry count never goes past the table depth.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    // Scan reads stay below the entry count.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && rd_en && !(r_chk_vld && match))
            |-> (CW'(rd_addr) < r_total))
        else $error("scan read beyond occupied entries");

    // A found key from a reverse lookup always comes with a hit.
    a_key_implies_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_key != KEY_NONE) |-> r_o_hit)
        else $error("key returned without hit");

endmodule
